### rtl/core/indexed_sequence_store_macros.svh
// Assertion macros shared by the checker of the indexed sequence store.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ISQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/isq_pkg.sv
// Package of the indexed sequence store: sizes, command and status codes,
// and the control word that the top level broadcasts to the cell row.
// No dependencies.
`default_nettype none

package isq_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned MAX_PC_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned CMP_W       = (MAX_PC_W > COUNT_OUT_W) ? MAX_PC_W : COUNT_OUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET      = 3'd0,
    CMD_ADD_HEAD = 3'd1,
    CMD_ADD_TAIL = 3'd2,
    CMD_ADD_AT   = 3'd3,
    CMD_DELETE   = 3'd4
  } isq_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } isq_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } isq_op_e;

  typedef struct packed {
    isq_op_e            op;
    logic [CMP_W-1:0]   pos;
    logic [DATA_W-1:0]  data;
  } isq_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/indexed_sequence_store.sv
// Indexed sequence store: usage.
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements
// in a row of cells and a count of the stored elements.
// The input channel carries one command with a position and a value; the
// output channel returns one result per command: the value read, a status
// and the element count after the command.
// A command transfer is decoded in the cycle it is accepted, the cells
// at and above its position shift toward a neighbor in that same cycle on
// an insert or delete, and the result appears in the output register on
// the next cycle. Throughput is one command per cycle while results are
// taken, set by the shift of the cell row and the one output register.
// The input is ready whenever the output register is empty or being taken,
// so a stalled receiver holds the result and blocks new commands only while
// that result waits.
// Reset empties the list and the output register; cell contents are not
// cleared, and only cells below the count are ever read.
// Depends on isq_pkg and isq_cell.
`default_nettype none

module indexed_sequence_store import isq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [POS_W-1:0]       position_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [COUNT_OUT_W-1:0] item_count_o
);

  logic                   accept;
  logic                   full;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       count_d;
  isq_ctrl_t              ctrl;
  isq_ctrl_t              cell_ctrl;
  isq_status_e            status_d;
  logic                   use_read;
  logic                   read_miss;
  logic [DATA_W-1:0]      rd_or;
  logic [DATA_W-1:0]      value_d;
  logic [CMP_W-1:0]       count_ext_d;
  logic                   out_valid_q;
  logic [DATA_W-1:0]      read_value_q;
  logic [STATUS_W-1:0]    status_q;
  logic [COUNT_OUT_W-1:0] item_count_q;
  logic [DATA_W-1:0]      cell_value [CAPACITY];
  logic [DATA_W-1:0]      cell_rd    [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign pos_ext    = CMP_W'(position_i);
  assign cnt_ext    = CMP_W'(count_q);

  always_comb begin
    ctrl.op   = OP_HOLD;
    ctrl.pos  = pos_ext;
    ctrl.data = data_value_i;
    status_d  = ST_DONE;
    use_read  = 1'b0;
    read_miss = 1'b0;
    count_d   = count_q;
    unique case (command_i)
      CMD_GET: begin
        if (pos_ext < cnt_ext) begin
          use_read = 1'b1;
        end else begin
          read_miss = 1'b1;
          status_d  = ST_RANGE;
        end
      end
      CMD_ADD_HEAD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.pos = '0;
          count_d  = count_q + 1'b1;
        end
      end
      CMD_ADD_TAIL: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.pos = cnt_ext;
          count_d  = count_q + 1'b1;
        end
      end
      CMD_ADD_AT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op = OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_ext < cnt_ext) begin
          ctrl.op = OP_DELETE;
          count_d = count_q - 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_comb begin
    cell_ctrl = ctrl;
    if (!accept) begin
      cell_ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = ctrl.data;
    end else begin : g_inner_l
      assign left = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_value[i];
    end else begin : g_inner_r
      assign right = cell_value[i+1];
    end

    isq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (cell_ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_value[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | cell_rd[k];
    end
  end

  always_comb begin
    if (use_read) begin
      value_d = rd_or;
    end else if (read_miss) begin
      value_d = '1;
    end else begin
      value_d = '0;
    end
  end

  assign count_ext_d = CMP_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= value_d;
      status_q     <= status_d;
      item_count_q <= count_ext_d[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign item_count_o = item_count_q;

endmodule

`default_nettype wire

### rtl/core/isq_cell.sv
// One cell of the element row: holds one element and shifts toward either
// neighbor on insert or delete. Depends on isq_pkg.
`default_nettype none

module isq_cell import isq_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  isq_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [CMP_W-1:0]  idx_ext;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;

  assign idx_ext = CMP_W'(idx_i);

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (idx_ext > ctrl_i.pos) begin
          value_d = left_i;
        end else if (idx_ext == ctrl_i.pos) begin
          value_d = ctrl_i.data;
        end
      end
      OP_DELETE: begin
        if (idx_ext >= ctrl_i.pos) begin
          value_d = right_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = (idx_ext == ctrl_i.pos) ? value_q : '0;

endmodule

`default_nettype wire

### rtl/core/isq_checker.sv
// Port-level checker of the indexed sequence store, bound to the top level.
// Depends on isq_pkg and indexed_sequence_store_macros.svh.
`default_nettype none

`include "indexed_sequence_store_macros.svh"

module isq_port_checker import isq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [DATA_W-1:0]      read_value_o,
  input logic [STATUS_W-1:0]    status_o,
  input logic [COUNT_OUT_W-1:0] item_count_o
);

  logic                                     in_xfer;
  logic                                     out_stall;
  logic                                     full_seen;
  logic                                     count_ok;
  logic [CMP_W-1:0]                         count_seen;
  logic [DATA_W+STATUS_W+COUNT_OUT_W-1:0]   result_seen;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign full_seen   = out_valid_o && (status_o == ST_FULL);
  assign count_seen  = CMP_W'(item_count_o);
  assign count_ok    = (count_seen <= CMP_W'(CAPACITY));
  assign result_seen = {read_value_o, status_o, item_count_o};

  `ISQ_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_o, "No result after a transfer.")
  `ISQ_ASSERT_SAME(a_ready_when_empty, !out_valid_o, in_ready_o, "Input stalled while empty.")
  `ISQ_ASSERT_NEXT(a_held, out_stall, out_valid_o && $stable(result_seen), "Stalled result changed.")
  `ISQ_ASSERT_SAME(a_full_no_value, full_seen, read_value_o == '0, "Refused insert gave a value.")
  `ISQ_ASSERT_SAME(a_count_bound, out_valid_o, count_ok, "Element count above capacity.")

endmodule

bind indexed_sequence_store isq_port_checker u_isq_checker (.*);

`default_nettype wire

### sim/isq_checker.sv
`timescale 1ns / 1ps
// Checker for the indexed sequence store. It watches both channels, keeps a
// shadow copy of the element list, and compares each result transfer with it.
// Depends on isq_pkg.
module isq_checker import isq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  input  logic [STATUS_W-1:0]      status_i,
  input  logic [COUNT_OUT_W-1:0]   item_count_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    isq_status_e              status;
    logic [COUNT_OUT_W-1:0]   item_count;
  } isq_result_t;

  logic [DATA_W-1:0] shadow_cells [CAPACITY];
  int unsigned       shadow_count = 0;
  isq_result_t       awaited_results [$];
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic isq_status_e insert_element(int unsigned at, logic [DATA_W-1:0] value);
    if (shadow_count >= CAPACITY) begin
      return ST_FULL;
    end
    for (int unsigned i = shadow_count; i > at; i--) begin
      shadow_cells[i] = shadow_cells[i-1];
    end
    shadow_cells[at] = value;
    shadow_count++;
    return ST_DONE;
  endfunction

  function automatic isq_result_t apply_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] value);
    isq_result_t r;
    r.read_value = '0;
    r.status     = ST_DONE;
    case (cmd)
      CMD_GET: begin
        if (pos < shadow_count) begin
          r.read_value = shadow_cells[pos];
        end else begin
          r.read_value = -1;
          r.status     = ST_RANGE;
        end
      end
      CMD_ADD_HEAD: begin
        r.status = insert_element(0, value);
      end
      CMD_ADD_TAIL: begin
        r.status = insert_element(shadow_count, value);
      end
      CMD_ADD_AT: begin
        if (pos > shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.status = insert_element(pos, value);
        end
      end
      CMD_DELETE: begin
        if (pos < shadow_count) begin
          for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_cells[i] = shadow_cells[i+1];
          end
          shadow_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    r.item_count = shadow_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    isq_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transfer: expected none, actual value %0d status %0d count %0d",
                   $time, read_value_i, status_i, item_count_i);
        end else begin
          want = awaited_results.pop_front();
          if (read_value_i !== want.read_value) begin
            mismatches++;
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, want.read_value, read_value_i);
          end
          if (status_i !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
          if (item_count_i !== want.item_count) begin
            mismatches++;
            $display("%0t: item_count mismatch: expected %0d, actual %0d",
                     $time, want.item_count, item_count_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_command(command_i, position_i, data_value_i));
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the indexed sequence store testbench: clock, reset, command stimulus
// and receiver stalls. Depends on isq_pkg, indexed_sequence_store and isq_checker.
module tb;
  import isq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LIMIT_NS     = 200000;
  localparam int          CMD_UNUSED_FIRST = 5;
  localparam int          CMD_UNUSED_LAST  = 7;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         command_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] read_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic [COUNT_OUT_W-1:0]   item_count_o;

  int unsigned fail_count;
  int unsigned results_outstanding;
  int unsigned list_length = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  indexed_sequence_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .data_value_i (data_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o)
  );

  isq_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .data_value_i (data_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_i (read_value_o),
    .status_i     (status_o),
    .item_count_i (item_count_o),
    .fail_count_o (fail_count),
    .pending_o    (results_outstanding)
  );

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    data_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    case (cmd)
      CMD_ADD_HEAD, CMD_ADD_TAIL: begin
        if (list_length < CAPACITY) list_length++;
      end
      CMD_ADD_AT: begin
        if (pos <= list_length && list_length < CAPACITY) list_length++;
      end
      CMD_DELETE: begin
        if (pos < list_length) list_length--;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // Receiver side: random stalls, one long hold-off, and a stretch of steady readiness.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic              grow;
    int unsigned       dwell;
    int unsigned       roll;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;

    grow  = 1'b1;
    dwell = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_command(CMD_GET, 0, 32'h0);
    send_command(CMD_DELETE, 0, 32'h0);
    send_command(CMD_ADD_AT, 1, 32'h1);
    send_command(CMD_ADD_AT, 0, 32'h7FFF_FFFF);
    send_command(CMD_ADD_HEAD, 0, 32'h8000_0000);
    send_command(CMD_ADD_TAIL, 0, 32'hFFFF_FFFF);
    send_command(CMD_ADD_TAIL, 0, 32'h0);
    send_command(CMD_ADD_AT, 2, 32'h1234_5678);
    send_command(CMD_ADD_AT, 5, 32'hA5A5_5A5A);
    send_command(CMD_ADD_AT, 127, 32'h5A5A_A5A5);
    send_command(CMD_GET, 0, 32'h0);
    send_command(CMD_GET, 2, 32'h0);
    send_command(CMD_GET, 5, 32'h0);
    send_command(CMD_GET, 6, 32'h0);
    send_command(CMD_GET, 127, 32'h0);
    send_command(CMD_DELETE, 5, 32'h0);
    send_command(CMD_DELETE, 0, 32'h0);
    send_command(CMD_DELETE, 1, 32'h0);
    send_command(CMD_DELETE, 127, 32'h0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
      send_command(CMD_W'(c), POS_W'($urandom_range(127)), $urandom);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_req <= 1'b1;
      if (n == 450) calm <= 1'b1;
      if (n == 550) calm <= 1'b0;
      if (n == 350) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (results_outstanding != 0);
      end

      // Alternate between filling the store up to its capacity and draining it.
      if (grow && list_length == CAPACITY) dwell++;
      if (!grow && list_length == 0) dwell++;
      if (grow && dwell > 12) begin
        grow  = 1'b0;
        dwell = 0;
      end else if (!grow && dwell > 4) begin
        grow  = 1'b1;
        dwell = 0;
      end

      roll = $urandom_range(99);
      if (roll < 5) begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      end else if (roll < 15) begin
        cmd = CMD_GET;
      end else if (roll < (grow ? 30 : 70)) begin
        cmd = CMD_DELETE;
      end else begin
        case ($urandom_range(2))
          0: cmd = CMD_ADD_HEAD;
          1: cmd = CMD_ADD_TAIL;
          default: cmd = CMD_ADD_AT;
        endcase
      end

      if ($urandom_range(99) < 20) begin
        pos = POS_W'($urandom_range(127));
      end else if (cmd == CMD_ADD_AT) begin
        pos = POS_W'($urandom_range(list_length));
      end else begin
        pos = (list_length == 0) ? '0 : POS_W'($urandom_range(list_length - 1));
      end

      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = '1;
          default: value = '0;
        endcase
      end else begin
        value = $urandom;
      end

      send_command(cmd, pos, value);
    end

    in_valid_i <= 1'b0;
    while (results_outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/isq_pkg.sv
rtl/core/isq_cell.sv
rtl/core/indexed_sequence_store.sv
rtl/core/isq_checker.sv
sim/isq_checker.sv
sim/tb.sv
